>>> src/mlp_pkg.sv
// package: widths, codes and types shared by the neuron engine modules
`default_nettype none
package mlp_pkg;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 32;
    localparam int MAX_INPUTS  = 64;
    localparam int MAX_HIDDEN  = 32;
    localparam int MAX_OUTPUTS = 8;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int LEN_W    = 7;

    localparam logic [ADDR_W-1:0] BASE_INPUT  = 16'h0000;
    localparam logic [ADDR_W-1:0] BASE_W1     = 16'h1000;
    localparam logic [ADDR_W-1:0] BASE_B1     = 16'h2000;
    localparam logic [ADDR_W-1:0] BASE_HIDDEN = 16'h3000;
    localparam logic [ADDR_W-1:0] BASE_W2     = 16'h4000;
    localparam logic [ADDR_W-1:0] BASE_B2     = 16'h5000;
    localparam logic [ADDR_W-1:0] BASE_OUTPUT = 16'h6000;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_HIDDEN = 2'd2;
    localparam logic [1:0] MODE_OUTPUT = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [1:0] REG_INPUT  = 2'd0;
    localparam logic [1:0] REG_HIDDEN = 2'd1;
    localparam logic [1:0] REG_OUTPUT = 2'd2;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]        mode;
        logic              skip;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic [4:0]        index;
        logic [ADDR_W-1:0] bias_addr;
        logic [ADDR_W-1:0] act_base;
        logic [ADDR_W-1:0] w_base;
        logic [ADDR_W-1:0] dest_addr;
        logic [LEN_W-1:0]  length;
    } cmd_t;
endpackage
`default_nettype wire

>>> src/mlp_neuron_mac_engine_unit.sv
// top level of the perceptron neuron engine
`default_nettype none
// Word-addressed Q16.16 neuron engine. A neuron compute reads the bias, then for each
// term (length = input or hidden count) an activation and a weight, through the single
// store port shared by bias, activation and weight fetches, with one multiply-accumulate
// per term. The front classifies items into a one-entry queue while the back computes;
// the back takes one item at a time.
module mlp_neuron_mac_engine_unit import mlp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [15:0] s_word_address,
    input  wire logic [31:0] s_write_value,
    input  wire logic [4:0]  s_neuron_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_read_value,
    output logic             m_done_kind,
    output logic [4:0]       m_done_index,
    output logic [1:0]       m_status
);
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    mlp_front u_front (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_mode, .s_word_address, .s_write_value, .s_neuron_index,
        .q_valid, .q_ready, .q_cmd
    );

    mlp_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_valid, .m_ready, .m_read_value, .m_done_kind, .m_done_index, .m_status
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_read_value)) else $error("result changed");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3) else $error("bad status");
endmodule
`default_nettype wire

>>> src/mlp_ram.sv
// generic single-port ram with registered read
`default_nettype none
module mlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> src/mlp_front.sv
// front end: config registers, item classification and address setup
`default_nettype none
module mlp_front import mlp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_mode,
    input  wire logic [15:0]       s_word_address,
    input  wire logic [31:0]       s_write_value,
    input  wire logic [4:0]        s_neuron_index,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output cmd_t                   q_cmd
);
    logic [6:0] in_cnt_reg;
    logic [5:0] hid_cnt_reg;
    logic [3:0] out_cnt_reg;
    logic [6:0] nin;
    logic [5:0] nh;
    logic [3:0] no;
    logic [12:0] row_off;
    cmd_t cmd;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_valid || q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_cnt_reg  <= 7'd49;
            hid_cnt_reg <= 6'd10;
            out_cnt_reg <= 4'd3;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_INPUT:  in_cnt_reg  <= cfg_data[6:0];
                REG_HIDDEN: hid_cnt_reg <= cfg_data[5:0];
                REG_OUTPUT: out_cnt_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign nin = (in_cnt_reg > 7'(MAX_INPUTS)) ? 7'(MAX_INPUTS) : in_cnt_reg;
    assign nh  = (hid_cnt_reg > 6'(MAX_HIDDEN)) ? 6'(MAX_HIDDEN) : hid_cnt_reg;
    assign no  = (out_cnt_reg > 4'(MAX_OUTPUTS)) ? 4'(MAX_OUTPUTS) : out_cnt_reg;

    always_comb begin
        row_off = (s_mode == MODE_HIDDEN) ? 13'(s_neuron_index) * 13'(nin)
                                          : 13'(s_neuron_index) * 13'(nh);
        cmd = '0;
        cmd.mode  = s_mode;
        cmd.addr  = s_word_address;
        cmd.wdata = s_write_value;
        cmd.index = s_neuron_index;
        if (s_mode == MODE_HIDDEN) begin
            cmd.skip      = ({1'b0, s_neuron_index} >= nh);
            cmd.bias_addr = BASE_B1 + 16'(s_neuron_index);
            cmd.act_base  = BASE_INPUT;
            cmd.w_base    = BASE_W1 + 16'(row_off);
            cmd.dest_addr = BASE_HIDDEN + 16'(s_neuron_index);
            cmd.length    = nin;
        end else if (s_mode == MODE_OUTPUT) begin
            cmd.skip      = (5'(no) <= s_neuron_index);
            cmd.bias_addr = BASE_B2 + 16'(s_neuron_index);
            cmd.act_base  = BASE_HIDDEN;
            cmd.w_base    = BASE_W2 + 16'(row_off);
            cmd.dest_addr = BASE_OUTPUT + 16'(s_neuron_index);
            cmd.length    = 7'(nh);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid <= 1'b0;
        end else if (s_ready) begin
            q_valid <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            q_cmd <= cmd;
        end
    end
endmodule
`default_nettype wire

>>> src/mlp_back.sv
// back end: store access and sequential multiply-accumulate
`default_nettype none
module mlp_back import mlp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire cmd_t        q_cmd,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_read_value,
    output logic             m_done_kind,
    output logic [4:0]       m_done_index,
    output logic [1:0]       m_status
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_BIAS, S_FETCH_A, S_FETCH_W, S_MUL, S_ADD, S_STORE
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] act_reg;
    logic signed [63:0] prod_reg;
    logic [31:0]       res_reg;
    logic [1:0]        st_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;
    logic signed [63:0] sum;
    logic signed [63:0] clip;
    logic              sat;

    mlp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign q_ready = (state_reg == S_IDLE) && !m_valid;

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = q_cmd.wdata;
        ram_addr  = q_cmd.addr;
        case (state_reg)
            S_IDLE: begin
                if (q_cmd.mode == MODE_WRITE || q_cmd.mode == MODE_READ) begin
                    ram_addr = q_cmd.addr;
                    ram_we   = q_valid && q_ready && q_cmd.mode == MODE_WRITE;
                end else begin
                    ram_addr = q_cmd.bias_addr;
                end
            end
            S_BIAS, S_ADD:  ram_addr = cmd_reg.act_base + 16'(cnt_reg);
            S_FETCH_A:      ram_addr = cmd_reg.w_base + 16'(cnt_reg);
            S_STORE: begin
                ram_addr  = cmd_reg.dest_addr;
                ram_wdata = res_reg;
                ram_we    = 1'b1;
            end
            default: ram_addr = cmd_reg.act_base + 16'(cnt_reg);
        endcase
    end

    // arithmetic shift is floor division by 2^16
    assign sum  = acc_reg + (prod_reg >>> 16);
    always_comb begin
        clip = sum;
        if (cmd_reg.mode == MODE_HIDDEN && sum < 0) begin
            clip = '0;
        end
        sat = 1'b0;
        if (clip > 64'sd2147483647) begin
            clip = 64'sd2147483647;
            sat  = 1'b1;
        end else if (clip < -64'sd2147483648) begin
            clip = -64'sd2147483648;
            sat  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid   <= 1'b0;
            acc_reg   <= '0;
        end else begin
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        cmd_reg <= q_cmd;
                        cnt_reg <= '0;
                        m_done_kind  <= (q_cmd.mode == MODE_OUTPUT);
                        m_done_index <= (q_cmd.mode[1]) ? q_cmd.index : 5'd0;
                        m_read_value <= '0;
                        m_status     <= ST_OK;
                        if (q_cmd.mode == MODE_WRITE) begin
                            m_valid <= 1'b1;
                        end else if (q_cmd.mode == MODE_READ) begin
                            state_reg <= S_READ;
                        end else if (q_cmd.skip) begin
                            m_status <= ST_RANGE;
                            m_valid  <= 1'b1;
                        end else begin
                            state_reg <= S_BIAS;
                        end
                    end
                end
                S_READ: begin
                    m_read_value <= ram_rdata;
                    m_valid      <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                S_BIAS: begin
                    acc_reg  <= 64'(signed'(ram_rdata));
                    prod_reg <= '0;
                    state_reg <= (cmd_reg.length == '0) ? S_ADD : S_FETCH_A;
                end
                S_FETCH_A: state_reg <= S_FETCH_W;
                S_FETCH_W: begin
                    act_reg   <= signed'(ram_rdata);
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= act_reg * signed'(ram_rdata);
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    acc_reg  <= sum;
                    prod_reg <= '0;
                    if (cnt_reg == cmd_reg.length) begin
                        res_reg   <= 32'(clip);
                        st_reg    <= sat ? ST_SAT : ST_OK;
                        state_reg <= S_STORE;
                    end else begin
                        state_reg <= S_FETCH_A;
                    end
                end
                S_STORE: begin
                    m_read_value <= res_reg;
                    m_status     <= st_reg;
                    m_valid      <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// testbench for the perceptron neuron engine: directed table, then predicted random traffic
module tb_top;
    import mlp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] addr;
        logic [31:0] wval;
        logic [4:0]  idx;
    } item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        kind;
        logic [4:0]  idx;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        item_t   item;
        logic    typed;
        result_t res;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = '0;
    logic [15:0] s_word_address = '0;
    logic [31:0] s_write_value = '0;
    logic [4:0]  s_neuron_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_value;
    logic        m_done_kind;
    logic [4:0]  m_done_index;
    logic [1:0]  m_status;

    mlp_neuron_mac_engine_unit DUT (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic [31:0] word_mem [0:65535];
    int unsigned n_inputs = 49, n_hid = 10, n_outputs = 3;
    result_t     pending_results [$];
    logic [15:0] written_addrs [$];
    int          errors = 0;
    bit          steady = 1'b0;
    bit          hold_req = 1'b0;

    function automatic result_t neuron_step(item_t it);
        result_t r;
        int unsigned nin, nh, no, len;
        logic [15:0] bias_a, act_a, w_a, dest_a;
        longint acc, a, w;
        r = '0;
        nin = n_inputs < MAX_INPUTS ? n_inputs : MAX_INPUTS;
        nh  = n_hid < MAX_HIDDEN ? n_hid : MAX_HIDDEN;
        no  = n_outputs < MAX_OUTPUTS ? n_outputs : MAX_OUTPUTS;
        case (it.mode)
            MODE_WRITE: word_mem[it.addr] = it.wval;
            MODE_READ: r.value = word_mem[it.addr];
            default: begin
                r.kind = (it.mode == MODE_OUTPUT);
                r.idx = it.idx;
                if (it.idx >= (r.kind ? no : nh)) begin
                    r.status = ST_RANGE;
                end else begin
                    len    = r.kind ? nh : nin;
                    bias_a = (r.kind ? BASE_B2 : BASE_B1) + it.idx;
                    act_a  = r.kind ? BASE_HIDDEN : BASE_INPUT;
                    w_a    = (r.kind ? BASE_W2 : BASE_W1) + 16'(it.idx * len);
                    dest_a = (r.kind ? BASE_OUTPUT : BASE_HIDDEN) + it.idx;
                    acc = longint'(signed'(word_mem[bias_a]));
                    for (int i = 0; i < len; i++) begin
                        a = longint'(signed'(word_mem[act_a + 16'(i)]));
                        w = longint'(signed'(word_mem[w_a + 16'(i)]));
                        acc += (a * w) >>> 16;
                    end
                    if (!r.kind && acc < 0) acc = 0;
                    r.status = ST_OK;
                    if (acc > 64'sh7FFFFFFF) begin
                        acc = 64'sh7FFFFFFF;
                        r.status = ST_SAT;
                    end
                    if (acc < -64'sh80000000) begin
                        acc = -64'sh80000000;
                        r.status = ST_SAT;
                    end
                    r.value = acc[31:0];
                    word_mem[dest_a] = acc[31:0];
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        int unsigned p;
        logic [31:0] v;
        p = $urandom_range(0, 99);
        if (p < 50) v = $urandom_range(0, 32'h3FFFF);
        else if (p < 70) v = $urandom_range(0, 32'hFFFFFF);
        else if (p < 90) return $urandom;
        else begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFFFFFF;
                1: return 32'h80000000;
                2: return 32'h0;
                default: return 32'hFFFFFFFF;
            endcase
        end
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [15:0] region_addr();
        case ($urandom_range(0, 6))
            0: return BASE_INPUT + 16'($urandom_range(0, 63));
            1: return BASE_W1 + 16'($urandom_range(0, 511));
            2: return BASE_B1 + 16'($urandom_range(0, 31));
            3: return BASE_HIDDEN + 16'($urandom_range(0, 31));
            4: return BASE_W2 + 16'($urandom_range(0, 255));
            5: return BASE_B2 + 16'($urandom_range(0, 7));
            default: return BASE_OUTPUT + 16'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic send_item(item_t it, bit typed, result_t typed_res);
        int unsigned gap;
        result_t r;
        s_mode <= it.mode;
        s_word_address <= it.addr;
        s_write_value <= it.wval;
        s_neuron_index <= it.idx;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = neuron_step(it);
        pending_results = {pending_results, (typed ? typed_res : r)};
        if (steady) gap = 0;
        else begin
            gap = $urandom_range(0, 99);
            gap = gap < 60 ? 0 : gap < 92 ? $urandom_range(1, 3) : $urandom_range(5, 30);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic preload_word(logic [15:0] a, logic [31:0] v);
        item_t it;
        it = {MODE_WRITE, a, v, 5'd0};
        send_item(it, 1'b0, '0);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_INPUT:  n_inputs = data[6:0];
            REG_HIDDEN: n_hid = data[5:0];
            REG_OUTPUT: n_outputs = data[3:0];
            default: ;
        endcase
    endtask

    task automatic set_counts(int unsigned ni, int unsigned nh, int unsigned no);
        write_reg(REG_INPUT, {$urandom} << 7 | ni);
        write_reg(REG_HIDDEN, {$urandom} << 6 | nh);
        write_reg(REG_OUTPUT, {$urandom} << 4 | no);
    endtask

    task automatic random_items(int unsigned count);
        item_t it;
        int unsigned p;
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(0, 99);
            it.wval = $urandom;
            it.idx = $urandom_range(0, 99) < 80 ? $urandom_range(0, 7) : $urandom_range(0, 31);
            if (p < 35) begin
                it.mode = MODE_WRITE;
                it.wval = rand_word();
                if ($urandom_range(0, 99) < 70) it.addr = region_addr();
                else begin
                    it.addr = $urandom;
                    written_addrs = {written_addrs, it.addr};
                end
            end else if (p < 60) begin
                it.mode = MODE_READ;
                if (written_addrs.size() > 0 && $urandom_range(0, 99) < 30)
                    it.addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                else
                    it.addr = region_addr();
            end else begin
                it.mode = p < 80 ? MODE_HIDDEN : MODE_OUTPUT;
                it.addr = $urandom;
                // hidden rows above 7 are not preloaded
                if (it.mode == MODE_HIDDEN && it.idx >= 5'd8 && it.idx < n_hid)
                    it.idx[4:3] = 2'b00;
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // result side: ready pattern and checking
    initial begin
        int unsigned stall = 0;
        int unsigned p;
        result_t got, want;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = {m_read_value, m_done_kind, m_done_index, m_status};
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected transfer: %h", got);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected value %h kind %0d idx %0d ",
                                      "status %0d, got value %h kind %0d idx %0d status %0d"},
                                     want.value, want.kind, want.idx, want.status,
                                     got.value, got.kind, got.idx, got.status);
                    end
                end
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                p = $urandom_range(0, 99);
                if (p < 3) begin
                    stall = $urandom_range(10, 50);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= p >= 25;
                end
            end
        end
    end

    // watchdog on transfers
    initial begin
        int unsigned quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        row_t table_rows [$];
        for (int i = 0; i < 65536; i++) word_mem[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // preload every word that computes and reads can touch
        for (int i = 0; i < 64; i++) preload_word(BASE_INPUT + 16'(i), rand_word() >>> 13);
        for (int i = 0; i < 512; i++) preload_word(BASE_W1 + 16'(i), rand_word() >>> 13);
        for (int i = 0; i < 32; i++) preload_word(BASE_B1 + 16'(i), rand_word() >>> 10);
        for (int i = 0; i < 32; i++) preload_word(BASE_HIDDEN + 16'(i), rand_word() >>> 13);
        for (int i = 0; i < 256; i++) preload_word(BASE_W2 + 16'(i), rand_word() >>> 13);
        for (int i = 0; i < 8; i++) preload_word(BASE_B2 + 16'(i), rand_word() >>> 10);
        for (int i = 0; i < 8; i++) preload_word(BASE_OUTPUT + 16'(i), rand_word());
        drain();

        set_counts(1, 1, 1);
        write_reg(REG_NONE, 32'h5);
        table_rows = '{
            '{'{MODE_WRITE, 16'hFFFF, 32'hFFFFFFFF, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_READ, 16'hFFFF, 32'h0, 5'd0}, 1, '{32'hFFFFFFFF, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_WRITE, BASE_INPUT, 32'h7FFFFFFF, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_WRITE, BASE_W1, 32'h7FFFFFFF, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_WRITE, BASE_B1, 32'h7FFFFFFF, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_HIDDEN, 16'h0, 32'h0, 5'd0}, 1, '{32'h7FFFFFFF, 1'b0, 5'd0, ST_SAT}},
            '{'{MODE_READ, BASE_HIDDEN, 32'h0, 5'd0}, 1, '{32'h7FFFFFFF, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_HIDDEN, 16'h0, 32'h0, 5'd31}, 1, '{32'h0, 1'b0, 5'd31, ST_RANGE}},
            '{'{MODE_HIDDEN, 16'h0, 32'h0, 5'd1}, 1, '{32'h0, 1'b0, 5'd1, ST_RANGE}},
            '{'{MODE_WRITE, BASE_W2, 32'h7FFFFFFF, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_WRITE, BASE_B2, 32'h80000000, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_WRITE, BASE_HIDDEN, 32'h80000000, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_OUTPUT, 16'h0, 32'h0, 5'd0}, 1, '{32'h80000000, 1'b1, 5'd0, ST_SAT}},
            '{'{MODE_READ, BASE_OUTPUT, 32'h0, 5'd0}, 1, '{32'h80000000, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_OUTPUT, 16'h0, 32'h0, 5'd31}, 1, '{32'h0, 1'b1, 5'd31, ST_RANGE}},
            '{'{MODE_OUTPUT, 16'h0, 32'h0, 5'd1}, 1, '{32'h0, 1'b1, 5'd1, ST_RANGE}},
            '{'{MODE_WRITE, BASE_INPUT, 32'h00010000, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_WRITE, BASE_W1, 32'hFFFF0000, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_WRITE, BASE_B1, 32'h0, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_HIDDEN, 16'h0, 32'h0, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_WRITE, BASE_B1, 32'h00028000, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_HIDDEN, 16'h0, 32'h0, 5'd0}, 1, '{32'h00018000, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_WRITE, BASE_W2, 32'h00030000, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_WRITE, BASE_B2, 32'hFFFF8000, 5'd0}, 1, '{32'h0, 1'b0, 5'd0, ST_OK}},
            '{'{MODE_OUTPUT, 16'h0, 32'h0, 5'd0}, 1, '{32'h00040000, 1'b1, 5'd0, ST_OK}}
        };
        foreach (table_rows[i]) send_item(table_rows[i].item, table_rows[i].typed, table_rows[i].res);
        drain();

        set_counts(64, 32, 8);
        random_items(40);
        drain();
        set_counts(127, 63, 15);
        hold_req = 1'b1;
        random_items(40);
        drain();
        set_counts(0, 0, 0);
        steady = 1'b1;
        random_items(30);
        steady = 1'b0;
        random_items(20);
        drain();
        set_counts(5, 3, 2);
        random_items(40);
        drain();
        set_counts(17, 20, 6);
        random_items(40);
        drain();
        set_counts($urandom_range(1, 64), $urandom_range(1, 32), $urandom_range(1, 8));
        random_items(40);
        drain();
        repeat (300) @(posedge aclk);

        if (errors == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
